// ----- design/bls_pkg.sv -----
// Shared types and constants for the Bresenham line stepper.
// Used by bls_engine, bls_out_reg and the top level; depends on nothing.
package bls_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Step directions of the running line
    typedef struct packed {
        logic steep;
        logic y_neg;
        logic x_neg;
    } dir_t;

    // Control of one result handed from the engine to the result register
    typedef struct packed {
        logic emit;
        logic last;
        logic value;
    } res_ctl_t;

    // Error term carries this many bits above the coordinate width
    localparam int ERR_EXTRA = 3;

endpackage

// ----- design/bls_in_reg.sv -----
// Input register of the line stepper: holds one accepted item until the engine takes it.
// Depends on nothing outside this file.
module bls_in_reg #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic                  ink,
    input  logic                  take,
    output logic                  item_valid,
    output logic                  item_op,
    output logic [COORD_BITS-1:0] item_start_x,
    output logic [COORD_BITS-1:0] item_start_y,
    output logic [COORD_BITS-1:0] item_end_x,
    output logic [COORD_BITS-1:0] item_end_y,
    output logic                  item_ink
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  op_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;
    logic                  ink_reg;
    logic                  load;

    // Hold the item while the engine cannot take it
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg      <= operation;
            start_x_reg <= start_x;
            start_y_reg <= start_y;
            end_x_reg   <= end_x;
            end_y_reg   <= end_y;
            ink_reg     <= ink;
        end
    end

    assign item_valid   = valid_reg;
    assign item_op      = op_reg;
    assign item_start_x = start_x_reg;
    assign item_start_y = start_y_reg;
    assign item_end_x   = end_x_reg;
    assign item_end_y   = end_y_reg;
    assign item_ink     = ink_reg;

endmodule

// ----- design/bls_engine.sv -----
// Line state and single-pass step logic: line setup on start, one Bresenham step on a step while a line runs.
// Depends on bls_pkg.
module bls_engine #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_op,
    input  logic [COORD_BITS-1:0] item_start_x,
    input  logic [COORD_BITS-1:0] item_start_y,
    input  logic [COORD_BITS-1:0] item_end_x,
    input  logic [COORD_BITS-1:0] item_end_y,
    input  logic                  item_ink,
    input  logic                  out_free,
    output logic                  take,
    output bls_pkg::res_ctl_t     res_ctl,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y
);

    localparam int N = COORD_BITS;
    localparam int E = COORD_BITS + bls_pkg::ERR_EXTRA;

    logic [N-1:0]      cur_x_reg, cur_x_next;
    logic [N-1:0]      cur_y_reg, cur_y_next;
    logic [N-1:0]      target_x_reg, target_x_next;
    logic [N-1:0]      target_y_reg, target_y_next;
    logic [E-1:0]      error_reg, error_next;
    logic [N:0]        major_twice_reg, major_twice_next;
    logic [N:0]        minor_twice_reg, minor_twice_next;
    bls_pkg::dir_t     dir_reg, dir_next;
    logic              busy_reg, busy_next;
    logic              ink_reg, ink_next;

    logic              is_start;
    logic              x_neg;
    logic              y_neg;
    logic [N-1:0]      adx;
    logic [N-1:0]      ady;
    logic              steep;
    logic [N-1:0]      maj;
    logic [N-1:0]      mnr;
    logic              point_line;

    logic [E-1:0]      err_sum;
    logic              diag;
    logic [E-1:0]      err_stepped;
    logic              move_x;
    logic              move_y;
    logic [N-1:0]      x_step;
    logic [N-1:0]      y_step;
    logic              reached;

    assign take     = item_valid && out_free;
    assign is_start = (item_op == bls_pkg::OP_START);

    // Line setup
    assign x_neg      = item_end_x < item_start_x;
    assign y_neg      = item_end_y < item_start_y;
    assign adx        = x_neg ? (item_start_x - item_end_x) : (item_end_x - item_start_x);
    assign ady        = y_neg ? (item_start_y - item_end_y) : (item_end_y - item_start_y);
    assign steep      = adx < ady;
    assign maj        = steep ? ady : adx;
    assign mnr        = steep ? adx : ady;
    assign point_line = (item_start_x == item_end_x) && (item_start_y == item_end_y);

    // One step: go diagonal when the error turns positive
    assign err_sum     = error_reg + {{(E-N-1){1'b0}}, minor_twice_reg};
    assign diag        = !err_sum[E-1] && (err_sum != '0);
    assign err_stepped = diag ? (err_sum - {{(E-N-1){1'b0}}, major_twice_reg}) : err_sum;
    assign move_x      = diag || !dir_reg.steep;
    assign move_y      = diag || dir_reg.steep;

    always_comb
    begin
        x_step = cur_x_reg;
        y_step = cur_y_reg;
        if (move_x)
        begin
            x_step = dir_reg.x_neg ? (cur_x_reg - N'(1)) : (cur_x_reg + N'(1));
        end
        if (move_y)
        begin
            y_step = dir_reg.y_neg ? (cur_y_reg - N'(1)) : (cur_y_reg + N'(1));
        end
    end

    assign reached = (x_step == target_x_reg) && (y_step == target_y_reg);

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        error_next       = error_reg;
        major_twice_next = major_twice_reg;
        minor_twice_next = minor_twice_reg;
        dir_next         = dir_reg;
        busy_next        = busy_reg;
        ink_next         = ink_reg;
        if (take && is_start)
        begin
            cur_x_next       = item_start_x;
            cur_y_next       = item_start_y;
            target_x_next    = item_end_x;
            target_y_next    = item_end_y;
            error_next       = E'(0) - {{(E-N){1'b0}}, maj};
            major_twice_next = {maj, 1'b0};
            minor_twice_next = {mnr, 1'b0};
            dir_next.steep   = steep;
            dir_next.y_neg   = y_neg;
            dir_next.x_neg   = x_neg;
            busy_next        = !point_line;
            ink_next         = item_ink;
        end
        else if (take && busy_reg)
        begin
            cur_x_next = x_step;
            cur_y_next = y_step;
            error_next = err_stepped;
            busy_next  = !reached;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            error_reg       <= '0;
            major_twice_reg <= '0;
            minor_twice_reg <= '0;
            dir_reg         <= '0;
            busy_reg        <= 1'b0;
            ink_reg         <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            error_reg       <= error_next;
            major_twice_reg <= major_twice_next;
            minor_twice_reg <= minor_twice_next;
            dir_reg         <= dir_next;
            busy_reg        <= busy_next;
            ink_reg         <= ink_next;
        end
    end

    // A step while idle is consumed and drops without a result
    always_comb
    begin
        res_ctl.emit  = take && (is_start || busy_reg);
        res_ctl.last  = is_start ? point_line : reached;
        res_ctl.value = is_start ? item_ink : ink_reg;
        res_x         = is_start ? item_start_x : x_step;
        res_y         = is_start ? item_start_y : y_step;
    end

endmodule

// ----- design/bls_out_reg.sv -----
// Result register of the line stepper: holds one pixel until the receiver takes it.
// Depends on bls_pkg.
module bls_out_reg #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bls_pkg::res_ctl_t     res_ctl,
    input  logic [COORD_BITS-1:0] res_x,
    input  logic [COORD_BITS-1:0] res_y,
    output logic                  out_free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  pixel_value,
    output logic                  last
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic                  value_reg;
    logic                  last_reg;

    // Free when empty or when the held pixel transfers this cycle
    assign out_free = !valid_reg || !out_stall;

    assign valid_next = out_free ? res_ctl.emit : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_ctl.emit)
        begin
            x_reg     <= res_x;
            y_reg     <= res_y;
            value_reg <= res_ctl.value;
            last_reg  <= res_ctl.last;
        end
    end

    assign out_valid   = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_value = value_reg;
    assign last        = last_reg;

endmodule

// ----- design/bresenham_line_stepper_core.sv -----
// Bresenham line stepper, top level.
// Instantiates bls_in_reg, bls_engine and bls_out_reg; uses bls_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries operation, both endpoints and ink.
//   operation = start loads a line and yields its first pixel; operation = step
//   yields the next pixel. A step with no line in progress yields nothing.
//   Output channel (out_valid / out_stall) carries pixel_x, pixel_y, pixel_value
//   and last; last marks the end point, after which the line is finished.
//   Path: an item is held in the input register and its pixel in the result register.
//   Throughput: one item per cycle while the receiver does not stall, set by the
//   combinational update of the line state (error add/subtract and coordinate
//   step) between input and result registers.
//   Receiver stall: the result register holds its pixel; the input register then
//   holds one more item and in_stall rises until the result transfers.
//   Reset: all line state clears, no line is in progress, both registers empty.
module bresenham_line_stepper_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic                  ink,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  pixel_value,
    output logic                  last
);

    logic                  take;
    logic                  item_valid;
    logic                  item_op;
    logic [COORD_BITS-1:0] item_start_x;
    logic [COORD_BITS-1:0] item_start_y;
    logic [COORD_BITS-1:0] item_end_x;
    logic [COORD_BITS-1:0] item_end_y;
    logic                  item_ink;
    logic                  out_free;
    bls_pkg::res_ctl_t     res_ctl;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;

    bls_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .ink          (ink),
        .take         (take),
        .item_valid   (item_valid),
        .item_op      (item_op),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y),
        .item_ink     (item_ink)
    );

    bls_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_op      (item_op),
        .item_start_x (item_start_x),
        .item_start_y (item_start_y),
        .item_end_x   (item_end_x),
        .item_end_y   (item_end_y),
        .item_ink     (item_ink),
        .out_free     (out_free),
        .take         (take),
        .res_ctl      (res_ctl),
        .res_x        (res_x),
        .res_y        (res_y)
    );

    bls_out_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_ctl     (res_ctl),
        .res_x       (res_x),
        .res_y       (res_y),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .last        (last)
    );

endmodule

// ----- design/bls_checker.sv -----
// Port-level checks for the Bresenham line stepper, bound to the top level.
// Depends only on the ports of bresenham_line_stepper_core.
module bls_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  pixel_value,
    input logic                  last
);

    // A held pixel stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A held pixel does not change
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_value) && $stable(last))
        else $error("output payload changed while stalled");

    // Input backpressure only comes from a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without a stalled result");

    // A new pixel appears only after an input transfer, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("pixel without an input transfer two cycles earlier");

endmodule

bind bresenham_line_stepper_core bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_value (pixel_value),
    .last        (last)
);
